>>> src/assert_macros.svh
// Assertion macros used by the checker file pcr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while reset is released.
`define PCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcr assertion failed");

// Check a property on every clock edge, reset included.
`define PCR_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pcr assertion failed");

`endif

>>> src/pcr_pkg.sv
// Shared constants for the particle contact resolver.
`default_nettype none
package pcr_pkg;
    localparam int COMPONENT_WIDTH = 21;
    localparam int FRAC_BITS       = 12;
    localparam int VEC_W           = 63;
    localparam int PEN_W           = 21;
    localparam int IM_W            = 24;
    localparam int TOT_W           = IM_W + 1;
    localparam int REST_W          = 17;
    localparam int FT_W            = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = REST_W;
    localparam int IN_TDATA_W      = 512;
    localparam int OUT_TDATA_W     = 256;
    localparam logic [REST_W-1:0] REST_ONE = 17'd65536;
    localparam logic [FT_W-1:0]   FT_RESET = 16'd1092;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME  = 1'b1;
endpackage
`default_nettype wire

>>> src/particle_contact_resolver_top.sv
// Top level of the particle contact resolver pipeline.
// One contact enters per cycle while the result side does not stall. Its result passes the front
// stages, then the restoring impulse divider (quotient width QW, 34 at the default component width
// of 21; the divider sets the depth, one quotient bit per stage), then the back stages. A stall on the
// result side freezes the whole pipeline; with the output taken every cycle the block sustains
// one contact per cycle. Write configuration only while no contact is in flight.
`default_nettype none
module particle_contact_resolver_top #(
    parameter int COMPONENT_WIDTH = pcr_pkg::COMPONENT_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [pcr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_a, pos_b, vel_a, vel_b, acc_a, acc_b, normal, penetration, inv_mass_a, inv_mass_b
    input  wire logic [pcr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // has_b
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // new_pos_a, new_pos_b, new_vel_a, new_vel_b, velocity_applied, position_applied
    output logic [pcr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    localparam int W    = COMPONENT_WIDTH;
    localparam int VW   = 3 * W;
    localparam int FB   = pcr_pkg::FRAC_BITS;
    localparam int IMW  = pcr_pkg::IM_W;
    localparam int TW   = pcr_pkg::TOT_W;
    localparam int RW   = pcr_pkg::REST_W;
    localparam int PW   = pcr_pkg::PEN_W - 1;
    localparam int SUMW = 2 * W + 3;
    localparam int SW   = SUMW - FB;
    localparam int DW   = SW + 1;
    localparam int QW   = (DW > PW) ? DW : PW;
    localparam int XW   = QW + IMW;
    localparam int MW   = W + QW + 1;
    localparam int AW   = MW + 1;
    localparam int VO   = pcr_pkg::VEC_W;
    localparam int PA_O = 0;
    localparam int PB_O = VW;
    localparam int VA_O = 2 * VW;
    localparam int VB_O = 3 * VW;
    localparam int N_O  = 4 * VW;
    localparam int HB_O = 5 * VW;
    localparam int TO_O = HB_O + 1;
    localparam int IM_O = TO_O + TW;
    localparam int PN_O = IM_O + IMW;
    localparam int PF_O = PN_O + PW;
    localparam int PLW  = PF_O + 1;
    localparam int SDW  = PLW + 1 + DW;
    localparam logic signed [AW-1:0] SMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = ~SMAX;

    logic ce;
    assign ce = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    logic [RW-1:0]            r_rest;
    logic [pcr_pkg::FT_W-1:0] r_ft;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= pcr_pkg::REST_ONE;
            r_ft   <= pcr_pkg::FT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pcr_pkg::CFG_RESTITUTION: r_rest <= i_cfg_data;
                pcr_pkg::CFG_FRAME_TIME:  r_ft   <= i_cfg_data[pcr_pkg::FT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [W-1:0] comp(input logic [VW-1:0] v, input int i);
        return $signed(v[i*W +: W]);
    endfunction

    function automatic logic [W-1:0] sat(input logic signed [AW-1:0] x);
        if (x > SMAX) return SMAX[W-1:0];
        if (x < SMIN) return SMIN[W-1:0];
        return x[W-1:0];
    endfunction

    // stage 1: unpack, relative vectors
    logic [9:0]               r_v;
    logic signed [W:0]        r1_rv [3];
    logic signed [W:0]        r1_ra [3];
    logic [PLW-1:0]           r1_pl;
    logic [RW-1:0]            r1_rest;
    logic [PLW-1:0]           n1_pl;
    logic [VW-1:0]            in_va, in_vb, in_aa, in_ab;
    logic signed [pcr_pkg::PEN_W-1:0] in_pen;
    logic [IMW-1:0]           in_ima, in_imb;
    logic                     in_hb, in_pf;
    logic [TW-1:0]            in_tot;

    always_comb begin
        in_va  = s_axis_tdata[2*VO +: VW];
        in_vb  = s_axis_tdata[3*VO +: VW];
        in_aa  = s_axis_tdata[4*VO +: VW];
        in_ab  = s_axis_tdata[5*VO +: VW];
        in_pen = $signed(s_axis_tdata[7*VO +: pcr_pkg::PEN_W]);
        in_ima = s_axis_tdata[7*VO + pcr_pkg::PEN_W +: IMW];
        in_hb  = s_axis_tuser;
        in_imb = in_hb ? s_axis_tdata[7*VO + pcr_pkg::PEN_W + IMW +: IMW] : '0;
        in_tot = TW'(in_ima) + TW'(in_imb);
        in_pf  = (in_pen > 0) && (in_tot != '0);
        n1_pl  = {in_pf, in_pen[PW-1:0] & {PW{in_pf}}, in_ima, in_tot, in_hb,
                  s_axis_tdata[6*VO +: VW], in_vb, in_va,
                  s_axis_tdata[VO +: VW], s_axis_tdata[0 +: VW]};
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r1_rv[i] <= (W+1)'(comp(in_va, i)) - (in_hb ? (W+1)'(comp(in_vb, i)) : '0);
                r1_ra[i] <= (W+1)'(comp(in_aa, i)) - (in_hb ? (W+1)'(comp(in_ab, i)) : '0);
            end
            r1_pl   <= n1_pl;
            r1_rest <= (r_rest > pcr_pkg::REST_ONE) ? pcr_pkg::REST_ONE : r_rest;
        end
    end

    // stage 2: products with the normal
    logic signed [2*W:0]  r2_prv [3];
    logic signed [2*W:0]  r2_pra [3];
    logic [PW+IMW-1:0]    r2_pdiv;
    logic [PLW-1:0]       r2_pl;
    logic [RW-1:0]        r2_rest;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r2_prv[i] <= r1_rv[i] * comp(r1_pl[N_O +: VW], i);
                r2_pra[i] <= r1_ra[i] * comp(r1_pl[N_O +: VW], i);
            end
            r2_pdiv <= r1_pl[PN_O +: PW] * r1_pl[IM_O +: IMW];
            r2_pl   <= r1_pl;
            r2_rest <= r1_rest;
        end
    end

    // stage 3: dot products
    logic signed [SUMW-1:0] s3_sv, s3_sa;
    logic signed [SW-1:0]   r3_sep, r3_dacc;
    logic                   r3_vf;
    logic [PW+IMW-1:0]      r3_pdiv;
    logic [PLW-1:0]         r3_pl;
    logic [RW-1:0]          r3_rest;

    always_comb begin
        s3_sv = SUMW'(r2_prv[0]) + SUMW'(r2_prv[1]) + SUMW'(r2_prv[2]);
        s3_sa = SUMW'(r2_pra[0]) + SUMW'(r2_pra[1]) + SUMW'(r2_pra[2]);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_sep  <= s3_sv[SUMW-1:FB];
            r3_dacc <= s3_sa[SUMW-1:FB];
            r3_vf   <= ($signed(s3_sv[SUMW-1:FB]) <= 0) && (r2_pl[TO_O +: TW] != '0);
            r3_pdiv <= r2_pdiv;
            r3_pl   <= r2_pl;
            r3_rest <= r2_rest;
        end
    end

    // stage 4: restitution and frame time products
    logic [SW+RW-1:0]          r4_m1;
    logic signed [SW+RW-1:0]   r4_m2;
    logic signed [SW-1:0]      r4_sep;
    logic                      r4_vf;
    logic [PW+IMW-1:0]         r4_pdiv;
    logic [PLW-1:0]            r4_pl;
    logic [RW-1:0]             r4_rest;
    logic [SW-1:0]             n4_neg;

    assign n4_neg = SW'(-r3_sep);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r4_m1   <= n4_neg * r3_rest;
            r4_m2   <= r3_dacc * $signed({1'b0, r_ft});
            r4_sep  <= r3_sep;
            r4_vf   <= r3_vf;
            r4_pdiv <= r3_pdiv;
            r4_pl   <= r3_pl;
            r4_rest <= r3_rest;
        end
    end

    // stage 5: scale back
    logic [SW:0]          r5_tgt;
    logic signed [SW:0]   r5_acc;
    logic signed [SW-1:0] r5_sep;
    logic                 r5_vf;
    logic [PW+IMW-1:0]    r5_pdiv;
    logic [PLW-1:0]       r5_pl;
    logic [RW-1:0]        r5_rest;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_tgt  <= r4_m1[SW+RW-1:16];
            r5_acc  <= r4_m2[SW+RW-1:16];
            r5_sep  <= r4_sep;
            r5_vf   <= r4_vf;
            r5_pdiv <= r4_pdiv;
            r5_pl   <= r4_pl;
            r5_rest <= r4_rest;
        end
    end

    // stage 6: restitution on the acceleration term
    logic signed [SW+RW+1:0] r6_m3;
    logic [SW:0]             r6_tgt;
    logic                    r6_neg;
    logic signed [SW-1:0]    r6_sep;
    logic                    r6_vf;
    logic [PW+IMW-1:0]       r6_pdiv;
    logic [PLW-1:0]          r6_pl;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r6_m3   <= r5_acc * $signed({1'b0, r5_rest});
            r6_tgt  <= r5_tgt;
            r6_neg  <= r5_acc < 0;
            r6_sep  <= r5_sep;
            r6_vf   <= r5_vf;
            r6_pdiv <= r5_pdiv;
            r6_pl   <= r5_pl;
        end
    end

    // stage 7: velocity change
    logic signed [SW+3:0] s7_t2, s7_d;
    logic [DW-1:0]        r7_delta;
    logic                 r7_vf;
    logic [PW+IMW-1:0]    r7_pdiv;
    logic [PLW-1:0]       r7_pl;

    always_comb begin
        s7_t2 = $signed({3'b000, r6_tgt});
        if (r6_neg) begin
            s7_t2 = s7_t2 + (SW+4)'($signed(r6_m3[SW+RW+1:16]));
            if (s7_t2 < 0) s7_t2 = '0;
        end
        s7_d = s7_t2 - (SW+4)'(r6_sep);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r7_delta <= s7_d[DW-1:0];
            r7_vf    <= r6_vf;
            r7_pdiv  <= r6_pdiv;
            r7_pl    <= r6_pl;
        end
    end

    // stage 8: dividends
    logic [DW+IMW-1:0] r8_vdiv;
    logic [DW-1:0]     r8_delta;
    logic              r8_vf;
    logic [PW+IMW-1:0] r8_pdiv;
    logic [PLW-1:0]    r8_pl;
    logic [TW-1:0]     n8_dvs;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r8_vdiv  <= r7_delta * r7_pl[IM_O +: IMW];
            r8_delta <= r7_delta;
            r8_vf    <= r7_vf;
            r8_pdiv  <= r7_pdiv;
            r8_pl    <= r7_pl;
        end
    end

    assign n8_dvs = (r8_pl[TO_O +: TW] == '0) ? TW'(1) : r8_pl[TO_O +: TW];

    logic            d_v;
    logic [QW-1:0]   d_qa, d_qb;
    logic [TW-1:0]   d_ra, d_rb;
    logic [SDW-1:0]  d_side;

    pcr_div #(
        .QW     (QW),
        .SIDE_W (SDW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (r_v[7]),
        .i_dvd_a  (XW'(r8_vdiv)),
        .i_dvd_b  (XW'(r8_pdiv)),
        .i_dvs    (n8_dvs),
        .i_side   ({r8_delta, r8_vf, r8_pl}),
        .o_valid  (d_v),
        .o_quot_a (d_qa),
        .o_rem_a  (d_ra),
        .o_quot_b (d_qb),
        .o_rem_b  (d_rb),
        .o_side   (d_side)
    );

    // stage 9: shares for both particles
    logic [PLW-1:0] d_pl;
    logic           d_vf, d_pf;
    logic [DW-1:0]  d_delta;
    logic [QW-1:0]  r9_sa, r9_sb, r9_ma, r9_mb;
    logic [PLW-1:0] r9_pl;
    logic           r9_vf, r9_pf;

    assign d_pl    = d_side[PLW-1:0];
    assign d_vf    = d_side[PLW];
    assign d_delta = d_side[PLW+1 +: DW];
    assign d_pf    = d_pl[PF_O];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r9_sa <= d_vf ? d_qa : '0;
            r9_sb <= d_vf ? QW'(QW'(d_delta) - d_qa - QW'(d_ra != '0)) : '0;
            r9_ma <= d_pf ? d_qb : '0;
            r9_mb <= d_pf ? QW'(QW'(d_pl[PN_O +: PW]) - d_qb - QW'(d_rb != '0)) : '0;
            r9_pl <= d_pl;
            r9_vf <= d_vf;
            r9_pf <= d_pf;
        end
    end

    // stage 10: move along the normal
    logic signed [MW-1:0] r10_va [3], r10_vb [3], r10_pa [3], r10_pb [3];
    logic [PLW-1:0]       r10_pl;
    logic                 r10_vf, r10_pf;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r10_va[i] <= comp(r9_pl[N_O +: VW], i) * $signed({1'b0, r9_sa});
                r10_vb[i] <= comp(r9_pl[N_O +: VW], i) * $signed({1'b0, r9_sb});
                r10_pa[i] <= comp(r9_pl[N_O +: VW], i) * $signed({1'b0, r9_ma});
                r10_pb[i] <= comp(r9_pl[N_O +: VW], i) * $signed({1'b0, r9_mb});
            end
            r10_pl <= r9_pl;
            r10_vf <= r9_vf;
            r10_pf <= r9_pf;
        end
    end

    // stage 11: add, saturate, pack
    logic [VW-1:0] n_npa, n_npb, n_nva, n_nvb;
    logic [pcr_pkg::OUT_TDATA_W-1:0] r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_npa[i*W +: W] = sat(AW'(comp(r10_pl[PA_O +: VW], i)) + AW'(r10_pa[i] >>> FB));
            n_npb[i*W +: W] = sat(AW'(comp(r10_pl[PB_O +: VW], i)) - AW'(r10_pb[i] >>> FB));
            n_nva[i*W +: W] = sat(AW'(comp(r10_pl[VA_O +: VW], i)) + AW'(r10_va[i] >>> FB));
            n_nvb[i*W +: W] = sat(AW'(comp(r10_pl[VB_O +: VW], i)) - AW'(r10_vb[i] >>> FB));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out <= {2'b00, r10_pf, r10_vf, VO'(n_nvb), VO'(n_nva), VO'(n_npb), VO'(n_npa)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (ce) begin
            r_v[7:0] <= {r_v[6:0], s_axis_tvalid};
            r_v[8]   <= d_v;
            r_v[9]   <= r_v[8];
        end
    end

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ce) begin
            r_ov <= r_v[9];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
endmodule
`default_nettype wire

>>> src/pcr_div.sv
// Pipelined restoring divider: two dividends over one shared divisor, one quotient bit per stage.
`default_nettype none
module pcr_div #(
    parameter int QW     = 34,
    parameter int SIDE_W = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_ce,
    input  wire logic                           i_valid,
    input  wire logic [QW+pcr_pkg::IM_W-1:0]    i_dvd_a,
    input  wire logic [QW+pcr_pkg::IM_W-1:0]    i_dvd_b,
    input  wire logic [pcr_pkg::TOT_W-1:0]      i_dvs,
    input  wire logic [SIDE_W-1:0]              i_side,
    output logic                                o_valid,
    output logic [QW-1:0]                       o_quot_a,
    output logic [pcr_pkg::TOT_W-1:0]           o_rem_a,
    output logic [QW-1:0]                       o_quot_b,
    output logic [pcr_pkg::TOT_W-1:0]           o_rem_b,
    output logic [SIDE_W-1:0]                   o_side
);
    localparam int TW = pcr_pkg::TOT_W;
    localparam int XW = QW + pcr_pkg::IM_W;

    logic [TW-1:0]     r_rem_a [QW];
    logic [QW-1:0]     r_lo_a  [QW];
    logic [TW-1:0]     r_rem_b [QW];
    logic [QW-1:0]     r_lo_b  [QW];
    logic [TW-1:0]     r_dvs   [QW];
    logic [SIDE_W-1:0] r_side  [QW];
    logic [QW-1:0]     r_v;

    function automatic logic [TW+QW-1:0] step(input logic [TW-1:0] rem,
                                              input logic [QW-1:0] lo,
                                              input logic [TW-1:0] d);
        logic [TW:0]   t;
        logic [TW-1:0] nr;
        logic          q;
        t = {rem, lo[QW-1]};
        if (t >= {1'b0, d}) begin
            nr = TW'(t - {1'b0, d});
            q  = 1'b1;
        end else begin
            nr = t[TW-1:0];
            q  = 1'b0;
        end
        return {nr, lo[QW-2:0], q};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            {r_rem_a[0], r_lo_a[0]} <= step({1'b0, i_dvd_a[XW-1:QW]}, i_dvd_a[QW-1:0], i_dvs);
            {r_rem_b[0], r_lo_b[0]} <= step({1'b0, i_dvd_b[XW-1:QW]}, i_dvd_b[QW-1:0], i_dvs);
            r_dvs[0]  <= i_dvs;
            r_side[0] <= i_side;
            for (int k = 1; k < QW; k++) begin
                {r_rem_a[k], r_lo_a[k]} <= step(r_rem_a[k-1], r_lo_a[k-1], r_dvs[k-1]);
                {r_rem_b[k], r_lo_b[k]} <= step(r_rem_b[k-1], r_lo_b[k-1], r_dvs[k-1]);
                r_dvs[k]  <= r_dvs[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid  = r_v[QW-1];
    assign o_quot_a = r_lo_a[QW-1];
    assign o_rem_a  = r_rem_a[QW-1];
    assign o_quot_b = r_lo_b[QW-1];
    assign o_rem_b  = r_rem_b[QW-1];
    assign o_side   = r_side[QW-1];
endmodule
`default_nettype wire

>>> src/pcr_checker.sv
// Port-level checker for the particle contact resolver, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pcr_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [pcr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    `PCR_ASSERT_ALL(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `PCR_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
    `PCR_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    `PCR_ASSERT(a_valid_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    `PCR_ASSERT(a_data_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
endmodule

bind particle_contact_resolver_top pcr_checker u_pcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
